// ===== hdl/fractal_lattice_noise_height_top_assert.svh =====
// Assertion macros for the terrain height block.
`ifndef FRACTAL_LATTICE_NOISE_HEIGHT_TOP_ASSERT_SVH
`define FRACTAL_LATTICE_NOISE_HEIGHT_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define FLNH_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define FLNH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/flnh_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package flnh_pkg;

    localparam int unsigned NUM_OCT = 3;
    localparam int unsigned COORD_W = 24;
    localparam int unsigned HEIGHT_W = 16;
    localparam int unsigned SINE_W = 16;
    localparam int unsigned CORNER_W = 17;
    localparam int unsigned SCALE_W = 18;

    localparam logic [31:0] PHASE_STEP = 32'd68356527;
    localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
    localparam int unsigned HEIGHT_LIMIT = 100;

    localparam logic [SCALE_W-1:0] OCT_SCALE [NUM_OCT] = '{18'd65536, 18'd19661, 18'd3277};
    localparam logic [6:0] OCT_GAIN [NUM_OCT] = '{7'd30, 7'd50, 7'd20};

    localparam longint unsigned ONE_Q30 = 64'd1073741824;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    // Sine in Q15 of a phase given in 2^32 per turn: odd polynomial on a quarter wave.
    function automatic logic signed [SINE_W-1:0] sine_entry(input logic [63:0] turn);
        longint unsigned quad;
        longint unsigned r;
        longint unsigned u;
        longint unsigned xv;
        longint unsigned x2;
        longint unsigned h;
        longint unsigned s;
        longint unsigned q;
        logic signed [SINE_W-1:0] mag;
        quad = (turn >> 30) & 64'd3;
        r = turn & (ONE_Q30 - 64'd1);
        u = ((quad & 64'd1) != 64'd0) ? ONE_Q30 - r : r;
        xv = (u * HALF_PI_Q30) >> 30;
        x2 = (xv * xv) >> 30;
        h = ONE_Q30 - x2 / 110;
        h = ONE_Q30 - ((x2 * h) >> 30) / 72;
        h = ONE_Q30 - ((x2 * h) >> 30) / 42;
        h = ONE_Q30 - ((x2 * h) >> 30) / 20;
        h = ONE_Q30 - ((x2 * h) >> 30) / 6;
        s = (xv * h) >> 30;
        q = (s + 64'd16384) >> 15;
        if (q > 64'd32767)
        begin
            q = 64'd32767;
        end
        mag = SINE_W'(q);
        return ((quad & 64'd2) != 64'd0) ? -mag : mag;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/fractal_lattice_noise_height_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Terrain height from three octaves of lattice value noise. Each item is one
// (x_coord, z_coord) pair in signed fixed point with FRAC_BITS fraction bits;
// each item gives one height_value in the same format, saturated to +-100.0.
// The block is a nine-stage pipeline: input register, coordinate scaling,
// lattice phase, sine table address, table read, corner product, blend along
// x, blend along z, then gain sum, rounding and saturation into the output
// register. It takes one item per clock unless the output register holds a
// result that is not taken. The whole pipe advances together whenever the
// output register is empty or being taken, so in_ready follows out_ready in
// a full pipe. Each octave holds its sine table of SINE_TABLE_DEPTH entries
// in two constant copies, one read at both sine corners and one at both
// cosine corners, with registered read data.
module fractal_lattice_noise_height_top #(
    parameter int unsigned FRAC_BITS = 8,
    parameter int unsigned SINE_TABLE_DEPTH = 1024
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic signed [23:0]   x_coord,
    input  wire logic signed [23:0]   z_coord,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic signed [15:0]        height_value
);

    localparam int unsigned NST = 9;
    localparam int unsigned NOCT = flnh_pkg::NUM_OCT;
    localparam int unsigned CW = flnh_pkg::COORD_W;
    localparam int unsigned IW = CW - FRAC_BITS;
    localparam int unsigned AW = $clog2(SINE_TABLE_DEPTH);
    localparam int unsigned SW = flnh_pkg::SINE_W;
    localparam int unsigned KW = flnh_pkg::CORNER_W;
    localparam int unsigned ABW = KW + FRAC_BITS + 1;
    localparam int unsigned OW = ABW + FRAC_BITS + 1;
    localparam int unsigned ACW = OW + 9;
    localparam int unsigned SH = 15 + FRAC_BITS;
    localparam int unsigned HW = ACW - SH;
    localparam longint LIM_RAW = longint'(flnh_pkg::HEIGHT_LIMIT) << FRAC_BITS;
    localparam longint LIM_FIN = (LIM_RAW > 32767) ? 32767 : LIM_RAW;
    localparam longint LIM_NEG = (LIM_RAW > 32768) ? -32768 : -LIM_RAW;
    localparam logic signed [HW-1:0] LIM_HI = HW'(LIM_FIN);
    localparam logic signed [HW-1:0] LIM_LO = HW'(LIM_NEG);
    localparam logic [FRAC_BITS:0] ONE_F = (FRAC_BITS+1)'(1) << FRAC_BITS;

    // Pipeline control: advance all stages together unless the result is held.
    logic [NST-1:0] v_reg;
    logic           adv;

    assign adv = !v_reg[NST-1] || out_ready;
    assign in_ready = adv;
    assign out_valid = v_reg[NST-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[NST-2:0], in_valid};
        end
    end

    // Stage 0: capture the coordinates.
    logic signed [CW-1:0] x_reg;
    logic signed [CW-1:0] z_reg;

    always_ff @(posedge clk)
    begin
        if (adv && in_valid)
        begin
            x_reg <= x_coord;
            z_reg <= z_coord;
        end
    end

    logic signed [OW-1:0] oct_reg [NOCT];

    for (genvar g = 0; g < NOCT; g++)
    begin : g_oct
        localparam logic [flnh_pkg::SCALE_W-1:0] SCALE = flnh_pkg::OCT_SCALE[g];

        // Stage 1: scale both coordinates, floor back to FRAC_BITS fraction bits.
        logic signed [CW+flnh_pkg::SCALE_W:0] xs_prod;
        logic signed [CW+flnh_pkg::SCALE_W:0] zs_prod;
        logic signed [CW-1:0] sx_reg;
        logic signed [CW-1:0] sz_reg;

        assign xs_prod = x_reg * $signed({1'b0, SCALE});
        assign zs_prod = z_reg * $signed({1'b0, SCALE});

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sx_reg <= xs_prod[16 +: CW];
                sz_reg <= zs_prod[16 +: CW];
            end
        end

        // Stage 2: lattice floor to phases, keep fractions.
        logic [31:0] ix_ext;
        logic [31:0] iz_ext;
        logic [31:0] px;
        logic [31:0] pz;
        logic [31:0] px0_reg;
        logic [31:0] px1_reg;
        logic [31:0] pz0_reg;
        logic [31:0] pz1_reg;
        logic [FRAC_BITS-1:0] fx2_reg;
        logic [FRAC_BITS-1:0] fz2_reg;

        assign ix_ext = {{(32-IW){sx_reg[CW-1]}}, sx_reg[CW-1:FRAC_BITS]};
        assign iz_ext = {{(32-IW){sz_reg[CW-1]}}, sz_reg[CW-1:FRAC_BITS]};
        assign px = 32'(ix_ext * flnh_pkg::PHASE_STEP);
        assign pz = 32'(iz_ext * flnh_pkg::PHASE_STEP) + flnh_pkg::QUARTER_TURN;

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                px0_reg <= px;
                px1_reg <= px + flnh_pkg::PHASE_STEP;
                pz0_reg <= pz;
                pz1_reg <= pz + flnh_pkg::PHASE_STEP;
                fx2_reg <= sx_reg[FRAC_BITS-1:0];
                fz2_reg <= sz_reg[FRAC_BITS-1:0];
            end
        end

        // Stage 3: phase to table address.
        logic [63:0] ax0;
        logic [63:0] ax1;
        logic [63:0] az0;
        logic [63:0] az1;
        logic [AW-1:0] ax0_reg;
        logic [AW-1:0] ax1_reg;
        logic [AW-1:0] az0_reg;
        logic [AW-1:0] az1_reg;
        logic [FRAC_BITS-1:0] fx3_reg;
        logic [FRAC_BITS-1:0] fz3_reg;

        assign ax0 = 64'(px0_reg) * 64'(SINE_TABLE_DEPTH);
        assign ax1 = 64'(px1_reg) * 64'(SINE_TABLE_DEPTH);
        assign az0 = 64'(pz0_reg) * 64'(SINE_TABLE_DEPTH);
        assign az1 = 64'(pz1_reg) * 64'(SINE_TABLE_DEPTH);

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                ax0_reg <= ax0[32 +: AW];
                ax1_reg <= ax1[32 +: AW];
                az0_reg <= az0[32 +: AW];
                az1_reg <= az1[32 +: AW];
                fx3_reg <= fx2_reg;
                fz3_reg <= fz2_reg;
            end
        end

        // Stage 4: table reads, two ports per copy.
        logic signed [SW-1:0] rom_sin [SINE_TABLE_DEPTH];
        logic signed [SW-1:0] rom_cos [SINE_TABLE_DEPTH];

        for (genvar j = 0; j < SINE_TABLE_DEPTH; j++)
        begin : g_rom
            localparam logic [63:0] TURN = (64'(j) << 32) / SINE_TABLE_DEPTH;
            assign rom_sin[j] = flnh_pkg::sine_entry(TURN);
            assign rom_cos[j] = flnh_pkg::sine_entry(TURN);
        end

        logic signed [SW-1:0] s0_reg;
        logic signed [SW-1:0] s1_reg;
        logic signed [SW-1:0] c0_reg;
        logic signed [SW-1:0] c1_reg;
        logic [FRAC_BITS-1:0] fx4_reg;
        logic [FRAC_BITS-1:0] fz4_reg;

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                s0_reg <= rom_sin[ax0_reg];
                s1_reg <= rom_sin[ax1_reg];
                c0_reg <= rom_cos[az0_reg];
                c1_reg <= rom_cos[az1_reg];
                fx4_reg <= fx3_reg;
                fz4_reg <= fz3_reg;
            end
        end

        // Stage 5: corner values, rounded half up to Q15.
        logic signed [2*SW:0] pa;
        logic signed [2*SW:0] pb;
        logic signed [2*SW:0] pc;
        logic signed [2*SW:0] pd;
        logic signed [KW-1:0] ka_reg;
        logic signed [KW-1:0] kb_reg;
        logic signed [KW-1:0] kc_reg;
        logic signed [KW-1:0] kd_reg;
        logic [FRAC_BITS-1:0] fx5_reg;
        logic [FRAC_BITS-1:0] fz5_reg;

        assign pa = (2*SW+1)'(s0_reg * c0_reg) + (2*SW+1)'(16384);
        assign pb = (2*SW+1)'(s1_reg * c0_reg) + (2*SW+1)'(16384);
        assign pc = (2*SW+1)'(s0_reg * c1_reg) + (2*SW+1)'(16384);
        assign pd = (2*SW+1)'(s1_reg * c1_reg) + (2*SW+1)'(16384);

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                ka_reg <= pa[15 +: KW];
                kb_reg <= pb[15 +: KW];
                kc_reg <= pc[15 +: KW];
                kd_reg <= pd[15 +: KW];
                fx5_reg <= fx4_reg;
                fz5_reg <= fz4_reg;
            end
        end

        // Stage 6: blend along x.
        logic signed [FRAC_BITS+1:0] wx1;
        logic signed [FRAC_BITS+1:0] wx0;
        logic signed [ABW-1:0] ab_reg;
        logic signed [ABW-1:0] cd_reg;
        logic [FRAC_BITS-1:0] fz6_reg;

        assign wx1 = $signed({2'b00, fx5_reg});
        assign wx0 = $signed({1'b0, ONE_F}) - wx1;

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                ab_reg <= ABW'(ka_reg * wx0) + ABW'(kb_reg * wx1);
                cd_reg <= ABW'(kc_reg * wx0) + ABW'(kd_reg * wx1);
                fz6_reg <= fz5_reg;
            end
        end

        // Stage 7: blend along z.
        logic signed [FRAC_BITS+1:0] wz1;
        logic signed [FRAC_BITS+1:0] wz0;

        assign wz1 = $signed({2'b00, fz6_reg});
        assign wz0 = $signed({1'b0, ONE_F}) - wz1;

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                oct_reg[g] <= OW'(ab_reg * wz0) + OW'(cd_reg * wz1);
            end
        end
    end

    // Stage 8: weighted octave sum, round half up, saturate.
    logic signed [ACW-1:0] acc;
    logic signed [ACW-1:0] acc_rnd;
    logic signed [HW-1:0]  h_full;
    logic signed [HW-1:0]  h_sat;
    logic signed [15:0]    height_reg;

    always_comb
    begin
        acc = '0;
        for (int g = 0; g < NOCT; g++)
        begin
            acc = acc + ACW'(oct_reg[g] * $signed({1'b0, flnh_pkg::OCT_GAIN[g]}));
        end
        acc_rnd = acc + (ACW'(1) <<< (SH - 1));
        h_full = acc_rnd[SH +: HW];
        if (h_full > LIM_HI)
        begin
            h_sat = LIM_HI;
        end
        else if (h_full < LIM_LO)
        begin
            h_sat = LIM_LO;
        end
        else
        begin
            h_sat = h_full;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            height_reg <= h_sat[15:0];
        end
    end

    assign height_value = height_reg;

    `include "fractal_lattice_noise_height_top_assert.svh"

    `FLNH_ASSERT_NOW(a_height_in_range, out_valid, (height_value <= 16'(LIM_HI)) && (height_value >= 16'(LIM_LO)), "height outside limit")
    `FLNH_ASSERT_NEXT(a_stall_freezes_pipe, !adv, $stable(v_reg), "valid bits moved during stall")
    `FLNH_ASSERT_NEXT(a_accept_enters, in_valid && in_ready, v_reg[0], "accepted item not in first stage")
    `FLNH_ASSERT_NEXT(a_count_kept, !adv, $countones(v_reg) == $countones($past(v_reg)), "item count changed in stall")

endmodule

`default_nettype wire
